FILE: sv/assert_macros.svh
// Shared assertion macros, clocked on clk_i and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sst assertion failed");

// Next-cycle implication.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sst assertion failed");

`endif

FILE: sv/sst_pkg.sv
package sst_pkg;

  localparam int unsigned ROWS_PER_COLUMN = 8;
  localparam int unsigned STEP_COLUMNS    = 8;
  localparam int unsigned PLANE_COUNT     = 4;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned INST_W   = 2;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned TAG_W    = 31;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MASK_W   = 3;

  localparam int unsigned S_FIELDS_W = CMD_W + INST_W + COL_W + TAG_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_FIELDS_W = STATUS_W + MASK_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  localparam logic [CMD_W-1:0] CMD_ADD           = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_ANY    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_TAGGED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PLAY          = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INSTRUMENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_COLUMN     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL           = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND      = 3'd4;

  typedef struct packed {
    logic [MASK_W-1:0] marks;
    logic [TAG_W-1:0]  tag;
  } slot_t;

endpackage

FILE: sv/step_sequencer_slot_table_top.sv
// channel   dir  tdata bits (low to high)
// s_axis    in   cmd[2:0] instrument[4:3] step_column[7:5] tag_id[38:8]
// m_axis    out  status[2:0] trigger_mask[5:3]
//
// Slot search reads the slot memory once per cycle through its single read port.
// add and play search one column; remove searches every slot; update searches every slot
// and then one column. Fields rejected at intake are answered without a search.
// After reset a clearing pass zeroes the memory; no beat
// is taken meanwhile. One item at a time; the next item may be taken while a result waits.
module step_sequencer_slot_table_top #(
  parameter int unsigned ROWS_PER_COLUMN = sst_pkg::ROWS_PER_COLUMN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd, instrument, step_column, tag_id, zero pad
  input  logic [sst_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, trigger_mask, zero pad
  output logic [sst_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SLOT_COUNT = ROWS_PER_COLUMN * sst_pkg::STEP_COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned INST_LO    = sst_pkg::CMD_W;
  localparam int unsigned COL_LO     = INST_LO + sst_pkg::INST_W;
  localparam int unsigned TAG_LO     = COL_LO + sst_pkg::COL_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_ADD,
    PH_REM_TAG,
    PH_REM_ANY,
    PH_PLAY
  } phase_e;

  logic [sst_pkg::CMD_W-1:0]    in_cmd;
  logic [sst_pkg::INST_W-1:0]   in_inst;
  logic [sst_pkg::COL_W-1:0]    in_col;
  logic [sst_pkg::TAG_W-1:0]    in_tag;
  logic                         in_inst_bad;
  logic                         in_col_bad;
  logic [ADDR_W-1:0]            in_col_base;

  state_e                       state_q, state_d;
  phase_e                       phase_q, phase_d;
  logic                         upd_q, upd_d;
  logic [sst_pkg::MASK_W-1:0]   inst_bit_q, inst_bit_d;
  logic [sst_pkg::COL_W-1:0]    col_q, col_d;
  logic [sst_pkg::TAG_W-1:0]    tag_q, tag_d;
  logic [ADDR_W-1:0]            base_q, base_d;
  logic [CNT_W-1:0]             len_q, len_d;
  logic [CNT_W-1:0]             iss_q, iss_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]            clr_q, clr_d;
  logic [sst_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [sst_pkg::MASK_W-1:0]   res_mask_q, res_mask_d;
  logic                         out_vld_q, out_vld_d;
  logic [sst_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [sst_pkg::MASK_W-1:0]   out_mask_q, out_mask_d;

  sst_pkg::slot_t               mem_q [SLOT_COUNT];
  sst_pkg::slot_t               rd_data_q;
  sst_pkg::slot_t               hit_data;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [ADDR_W-1:0]            mem_raddr;
  sst_pkg::slot_t               mem_wdata;

  logic                         hit;
  logic                         last_rd;
  logic                         phase_done;
  logic                         col_bad_q;
  logic [ADDR_W-1:0]            col_base_q;

  assign in_cmd  = s_axis_tdata[sst_pkg::CMD_W-1:0];
  assign in_inst = s_axis_tdata[COL_LO-1:INST_LO];
  assign in_col  = s_axis_tdata[TAG_LO-1:COL_LO];
  assign in_tag  = s_axis_tdata[TAG_LO+sst_pkg::TAG_W-1:TAG_LO];

  assign in_inst_bad = (in_inst == '0) || (int'(in_inst) >= sst_pkg::PLANE_COUNT);
  assign in_col_bad  = int'(in_col) >= sst_pkg::STEP_COLUMNS;
  assign in_col_base = ADDR_W'(int'(in_col) * ROWS_PER_COLUMN);
  assign col_bad_q   = int'(col_q) >= sst_pkg::STEP_COLUMNS;
  assign col_base_q  = ADDR_W'(int'(col_q) * ROWS_PER_COLUMN);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{sst_pkg::M_PAD_W{1'b0}}, out_mask_q, out_status_q};

  assign last_rd = (iss_q == len_q);

  always_comb begin
    hit      = 1'b0;
    hit_data = rd_data_q;
    case (phase_q)
      PH_ADD: begin
        hit            = (rd_data_q.tag == '0);
        hit_data.marks = rd_data_q.marks | inst_bit_q;
        hit_data.tag   = tag_q;
      end
      PH_REM_TAG: begin
        hit            = (rd_data_q.tag == tag_q);
        hit_data.marks = rd_data_q.marks & ~inst_bit_q;
        hit_data.tag   = '0;
      end
      PH_REM_ANY: begin
        hit            = (rd_data_q.tag == tag_q) && (rd_data_q.marks != '0);
        hit_data.marks = rd_data_q.marks & (rd_data_q.marks - 1'b1);
        hit_data.tag   = '0;
      end
      PH_PLAY: begin
        hit = 1'b0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    upd_d        = upd_q;
    inst_bit_d   = inst_bit_q;
    col_d        = col_q;
    tag_d        = tag_q;
    base_d       = base_q;
    len_d        = len_q;
    iss_d        = iss_q;
    rd_vld_d     = 1'b0;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_mask_d   = res_mask_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_mask_d   = out_mask_q;
    mem_we       = 1'b0;
    mem_waddr    = base_q + ADDR_W'(iss_q - 1'b1);
    mem_raddr    = base_q + ADDR_W'(iss_q);
    mem_wdata    = hit_data;
    phase_done   = 1'b0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(SLOT_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          inst_bit_d   = sst_pkg::MASK_W'(1) << (in_inst - 1'b1);
          col_d        = in_col;
          tag_d        = in_tag;
          iss_d        = '0;
          upd_d        = 1'b0;
          res_status_d = sst_pkg::ST_OK;
          res_mask_d   = '0;
          base_d       = '0;
          len_d        = CNT_W'(SLOT_COUNT);
          state_d      = S_SCAN;
          case (in_cmd)
            sst_pkg::CMD_ADD: begin
              phase_d = PH_ADD;
              base_d  = in_col_base;
              len_d   = CNT_W'(ROWS_PER_COLUMN);
              if (in_inst_bad) begin
                res_status_d = sst_pkg::ST_BAD_INSTRUMENT;
                state_d      = S_FIN;
              end else if (in_col_bad) begin
                res_status_d = sst_pkg::ST_BAD_COLUMN;
                state_d      = S_FIN;
              end
            end
            sst_pkg::CMD_UPDATE: begin
              phase_d = PH_REM_TAG;
              upd_d   = 1'b1;
              if (in_inst_bad) begin
                res_status_d = sst_pkg::ST_BAD_INSTRUMENT;
                state_d      = S_FIN;
              end
            end
            sst_pkg::CMD_REMOVE_ANY: begin
              phase_d = PH_REM_ANY;
            end
            sst_pkg::CMD_REMOVE_TAGGED: begin
              phase_d = PH_REM_TAG;
              if (in_inst_bad) begin
                res_status_d = sst_pkg::ST_BAD_INSTRUMENT;
                state_d      = S_FIN;
              end
            end
            sst_pkg::CMD_PLAY: begin
              phase_d = PH_PLAY;
              base_d  = in_col_base;
              len_d   = CNT_W'(ROWS_PER_COLUMN);
              if (in_col_bad) begin
                res_status_d = sst_pkg::ST_BAD_COLUMN;
                state_d      = S_FIN;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!last_rd) begin
          rd_vld_d = 1'b1;
          iss_d    = iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (phase_q == PH_PLAY) begin
            res_mask_d = res_mask_q | rd_data_q.marks;
          end
          if (hit) begin
            mem_we       = 1'b1;
            rd_vld_d     = 1'b0;
            iss_d        = iss_q;
            phase_done   = 1'b1;
            res_status_d = sst_pkg::ST_OK;
          end else if (last_rd) begin
            phase_done = 1'b1;
            case (phase_q)
              PH_ADD:  res_status_d = sst_pkg::ST_FULL;
              PH_PLAY: res_status_d = sst_pkg::ST_OK;
              default: res_status_d = sst_pkg::ST_NOT_FOUND;
            endcase
          end
        end
        if (phase_done) begin
          if (upd_q && (phase_q == PH_REM_TAG)) begin
            // hand over to the add pass; the removal result is dropped
            upd_d    = 1'b0;
            phase_d  = PH_ADD;
            base_d   = col_base_q;
            len_d    = CNT_W'(ROWS_PER_COLUMN);
            iss_d    = '0;
            rd_vld_d = 1'b0;
            if (col_bad_q) begin
              res_status_d = sst_pkg::ST_BAD_COLUMN;
              state_d      = S_FIN;
            end
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_mask_d   = res_mask_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      phase_q      <= PH_ADD;
      upd_q        <= 1'b0;
      inst_bit_q   <= '0;
      col_q        <= '0;
      tag_q        <= '0;
      base_q       <= '0;
      len_q        <= '0;
      iss_q        <= '0;
      rd_vld_q     <= 1'b0;
      clr_q        <= '0;
      res_status_q <= '0;
      res_mask_q   <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= '0;
      out_mask_q   <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      upd_q        <= upd_d;
      inst_bit_q   <= inst_bit_d;
      col_q        <= col_d;
      tag_q        <= tag_d;
      base_q       <= base_d;
      len_q        <= len_d;
      iss_q        <= iss_d;
      rd_vld_q     <= rd_vld_d;
      clr_q        <= clr_d;
      res_status_q <= res_status_d;
      res_mask_q   <= res_mask_d;
      out_vld_q    <= out_vld_d;
      out_status_q <= out_status_d;
      out_mask_q   <= out_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

endmodule

FILE: sv/sst_checker.sv
`include "assert_macros.svh"

module sst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sst_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sst_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [sst_pkg::STATUS_W-1:0] status;
  logic [sst_pkg::MASK_W-1:0]   mask;
  logic                         stalled;

  assign status  = m_axis_tdata[sst_pkg::STATUS_W-1:0];
  assign mask    = m_axis_tdata[sst_pkg::M_FIELDS_W-1:sst_pkg::STATUS_W];
  assign stalled = m_axis_tvalid && !m_axis_tready;

  `SST_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata))
  `SST_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SST_ASSERT_IMPL(a_status_code, m_axis_tvalid, status <= sst_pkg::ST_NOT_FOUND)
  `SST_ASSERT_IMPL(a_mask_only_ok, m_axis_tvalid && (mask != '0), status == sst_pkg::ST_OK)

endmodule

bind step_sequencer_slot_table_top sst_checker u_sst_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import sst_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
  localparam logic [INST_W-1:0] INST_NONE   = 2'd0;
  localparam logic [TAG_W-1:0]  TAG_MAX     = 31'h7FFF_FFFF;
  localparam logic [MASK_W-1:0] MASK_NONE   = 3'd0;

  localparam int unsigned SLOTS          = ROWS_PER_COLUMN * STEP_COLUMNS;
  localparam int unsigned N_DIRECTED     = 23;
  localparam int unsigned N_RANDOM       = 1000;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned S_PAD_W        = S_TDATA_W - S_FIELDS_W;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [INST_W-1:0]   inst;
    logic [COL_W-1:0]    col;
    logic [TAG_W-1:0]    tag;
    bit                  typed_exp;
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   mask;
  } seq_cmd_t;

  typedef struct {
    int unsigned         item;
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   mask;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // cmd, instrument, step_column, tag_id, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // status, trigger_mask, zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;

  seq_cmd_t    stim_q[$];
  outcome_t    pending_q[$];
  logic [TAG_W-1:0]  grid_tag[SLOTS];
  logic [MASK_W-1:0] grid_marks[SLOTS];
  int unsigned send_idx = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned phase_now = 0;
  int unsigned sender_idle_pct[4] = '{0, 49, 0, 32};
  int unsigned recv_stall_pct[4]  = '{0, 0, 49, 32};

  seq_cmd_t directed_rows[N_DIRECTED] = '{
    '{CMD_PLAY,          2'd1,      3'd0, 31'd0,          1'b1, ST_OK,             MASK_NONE},
    '{CMD_PLAY,          2'd3,      3'd7, TAG_MAX,        1'b1, ST_OK,             MASK_NONE},
    '{CMD_ADD,           INST_NONE, 3'd3, 31'd9,          1'b1, ST_BAD_INSTRUMENT, MASK_NONE},
    '{CMD_REMOVE_TAGGED, INST_NONE, 3'd3, 31'd9,          1'b1, ST_BAD_INSTRUMENT, MASK_NONE},
    '{CMD_UPDATE,        INST_NONE, 3'd3, 31'd9,          1'b1, ST_BAD_INSTRUMENT, MASK_NONE},
    '{CMD_REMOVE_ANY,    INST_NONE, 3'd0, 31'd5,          1'b1, ST_NOT_FOUND,      MASK_NONE},
    '{CMD_REMOVE_TAGGED, 2'd1,      3'd0, TAG_MAX,        1'b1, ST_NOT_FOUND,      MASK_NONE},
    '{CMD_ADD,           2'd3,      3'd7, TAG_MAX,        1'b1, ST_OK,             MASK_NONE},
    '{CMD_PLAY,          2'd0,      3'd7, 31'd0,          1'b1, ST_OK,             3'b100},
    '{CMD_ADD,           2'd1,      3'd0, 31'd0,          1'b0, ST_OK,             MASK_NONE},
    '{CMD_ADD,           2'd2,      3'd0, 31'd0,          1'b0, ST_OK,             MASK_NONE},
    '{CMD_PLAY,          2'd2,      3'd0, 31'd0,          1'b0, ST_OK,             MASK_NONE},
    '{CMD_REMOVE_ANY,    2'd3,      3'd0, 31'd0,          1'b0, ST_OK,             MASK_NONE},
    '{CMD_REMOVE_TAGGED, 2'd2,      3'd0, 31'd0,          1'b0, ST_OK,             MASK_NONE},
    '{CMD_UPDATE,        2'd1,      3'd7, TAG_MAX,        1'b0, ST_OK,             MASK_NONE},
    '{CMD_UPDATE,        2'd2,      3'd6, 31'h2AAA_AAAA,  1'b0, ST_OK,             MASK_NONE},
    '{CMD_REMOVE_ANY,    2'd1,      3'd1, 31'h5555_5555,  1'b1, ST_NOT_FOUND,      MASK_NONE},
    '{CMD_REMOVE_TAGGED, 2'd3,      3'd6, 31'h2AAA_AAAA,  1'b0, ST_OK,             MASK_NONE},
    '{CMD_PLAY,          2'd1,      3'd6, 31'd0,          1'b0, ST_OK,             MASK_NONE},
    '{CMD_SPARE_5,       INST_NONE, 3'd0, 31'd0,          1'b1, ST_OK,             MASK_NONE},
    '{CMD_SPARE_6,       2'd2,      3'd5, 31'h0123_4567,  1'b1, ST_OK,             MASK_NONE},
    '{CMD_SPARE_7,       2'd3,      3'd7, TAG_MAX,        1'b1, ST_OK,             MASK_NONE},
    '{CMD_PLAY,          2'd3,      3'd7, TAG_MAX,        1'b0, ST_OK,             MASK_NONE}
  };

  step_sequencer_slot_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [STATUS_W-1:0] place_tag(logic [INST_W-1:0] inst,
                                                     logic [COL_W-1:0] col,
                                                     logic [TAG_W-1:0] tag);
    int unsigned s;
    if (inst == INST_NONE) return ST_BAD_INSTRUMENT;
    if (col >= STEP_COLUMNS) return ST_BAD_COLUMN;
    for (int unsigned r = 0; r < ROWS_PER_COLUMN; r++) begin
      s = col * ROWS_PER_COLUMN + r;
      if (grid_tag[s] == '0) begin
        grid_tag[s] = tag;
        grid_marks[s][int'(inst) - 1] = 1'b1;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic logic [STATUS_W-1:0] drop_tagged(logic [INST_W-1:0] inst,
                                                       logic [TAG_W-1:0] tag);
    if (inst == INST_NONE) return ST_BAD_INSTRUMENT;
    for (int unsigned s = 0; s < SLOTS; s++) begin
      if (grid_tag[s] == tag) begin
        grid_tag[s] = '0;
        grid_marks[s][int'(inst) - 1] = 1'b0;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  function automatic void apply_command(input seq_cmd_t b, output logic [STATUS_W-1:0] st,
                                        output logic [MASK_W-1:0] mk);
    logic [STATUS_W-1:0] ignored;
    st = ST_OK;
    mk = MASK_NONE;
    case (b.cmd)
      CMD_ADD: begin
        st = place_tag(b.inst, b.col, b.tag);
      end
      CMD_UPDATE: begin
        ignored = drop_tagged(b.inst, b.tag);
        st = place_tag(b.inst, b.col, b.tag);
      end
      CMD_REMOVE_ANY: begin
        st = ST_NOT_FOUND;
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (st == ST_NOT_FOUND && grid_tag[s] == b.tag && grid_marks[s] != '0) begin
            grid_tag[s] = '0;
            grid_marks[s] = grid_marks[s] & (grid_marks[s] - 1'b1);
            st = ST_OK;
          end
        end
      end
      CMD_REMOVE_TAGGED: begin
        st = drop_tagged(b.inst, b.tag);
      end
      CMD_PLAY: begin
        if (b.col >= STEP_COLUMNS) begin
          st = ST_BAD_COLUMN;
        end else begin
          for (int unsigned r = 0; r < ROWS_PER_COLUMN; r++)
            mk = mk | grid_marks[b.col * ROWS_PER_COLUMN + r];
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return TAG_MAX;
    if (r < 22) return TAG_W'($urandom());
    return TAG_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [INST_W-1:0] pick_inst();
    if ($urandom_range(7) == 0) return INST_NONE;
    return INST_W'($urandom_range(3, 1));
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    if ($urandom_range(99) < 60) return ($urandom_range(1) != 0) ? 3'd2 : 3'd5;
    return COL_W'($urandom_range(7));
  endfunction

  function automatic void build_stimulus();
    seq_cmd_t b;
    int unsigned r;
    logic [COL_W-1:0] col;
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    while (stim_q.size() < N_DIRECTED + N_RANDOM) begin
      b = '{CMD_PLAY, pick_inst(), pick_col(), pick_tag(), 1'b0, ST_OK, MASK_NONE};
      r = $urandom_range(99);
      if (r < 3) begin
        // fill one column past its capacity
        col = pick_col();
        for (int unsigned k = 0; k <= ROWS_PER_COLUMN; k++) begin
          b = '{CMD_ADD, INST_W'($urandom_range(3, 1)), col,
                TAG_W'($urandom_range(12, 1)), 1'b0, ST_OK, MASK_NONE};
          stim_q.push_back(b);
        end
        b.cmd = CMD_PLAY;
      end else if (r < 35) begin
        b.cmd = CMD_ADD;
      end else if (r < 50) begin
        b.cmd = CMD_UPDATE;
      end else if (r < 63) begin
        b.cmd = CMD_REMOVE_ANY;
      end else if (r < 78) begin
        b.cmd = CMD_REMOVE_TAGGED;
      end else if (r < 95) begin
        b.cmd = CMD_PLAY;
      end else begin
        b.cmd = CMD_W'($urandom_range(7, 5));
      end
      stim_q.push_back(b);
    end
  endfunction

  function automatic int unsigned phase_of(int unsigned idx);
    if (idx < N_DIRECTED) return 0;
    return ((idx - N_DIRECTED) * 4) / (stim_q.size() - N_DIRECTED + 1);
  endfunction

  task automatic report_mismatch(string what, int unsigned item, logic [2:0] got,
                                 logic [2:0] want);
    $display("[%0t] item %0d: %s got %0d expected %0d", $time, item, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    seq_cmd_t b;
    outcome_t o;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        b = stim_q[accepted_cnt];
        o.item = accepted_cnt;
        apply_command(b, o.status, o.mask);
        if (b.typed_exp) begin
          o.status = b.status;
          o.mask = b.mask;
        end
        pending_q.push_back(o);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_idx < stim_q.size() &&
            $urandom_range(99) >= sender_idle_pct[phase_of(send_idx)]) begin
          b = stim_q[send_idx];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{S_PAD_W{1'b0}}, b.tag, b.col, b.inst, b.cmd};
          phase_now     <= phase_of(send_idx);
          send_idx      <= send_idx + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t o;
    logic [STATUS_W-1:0] got_status;
    logic [MASK_W-1:0]   got_mask;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[STATUS_W-1:0];
        got_mask   = m_axis_tdata[STATUS_W+MASK_W-1:STATUS_W];
        if (pending_q.size() == 0) begin
          report_mismatch("beat with nothing pending, status", result_cnt, got_status, '0);
        end else begin
          o = pending_q.pop_front();
          if (got_status !== o.status) report_mismatch("status", o.item, got_status, o.status);
          if (got_mask !== o.mask) report_mismatch("trigger_mask", o.item, got_mask, o.mask);
        end
        result_cnt <= result_cnt + 1;
      end
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct[phase_now];
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat in %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (grid_tag[s]) begin
      grid_tag[s] = '0;
      grid_marks[s] = '0;
    end
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_cnt < stim_q.size() || pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/sst_pkg.sv
sv/step_sequencer_slot_table_top.sv
sv/sst_checker.sv
test/tb.sv
